// ----- rtl/brb_pkg.sv -----
// Package for the byte ring buffer: defaults, field widths, operation codes and state type.
package brb_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_RUN_DEF = 64;

    localparam int CAP_W    = 11;
    localparam int COUNT_W  = 11;
    localparam int FUNC_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 12;
    localparam int CAP_RESET = 1024;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_PUSH    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SKIP    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_ADVANCE = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DATA = 3'b100
    } state_t;

endpackage

// ----- rtl/byte_ring_buffer.sv -----
// Byte ring buffer: byte FIFO in a circular single-port memory with a programmable wrap point.
//
// Each input word names one operation (push, pop run, peek run, clear, skip read side,
// advance write side). Push, clear, skip, advance and any refused operation give one result
// word and the block takes the next input word in the following cycle, so these run at one
// word per cycle while the result register drains. A pop or peek run of n bytes goes to
// ST_READ, which issues the first memory read, then to ST_DATA, which loads each byte into the
// result register when it is free and reads the next; no new input word is taken until the
// last byte of the run has been loaded into the result register. Writing the capacity register
// empties the ring. The byte store is not cleared after reset, so no clearing pass is needed.
module byte_ring_buffer #(
    parameter int DEPTH   = brb_pkg::DEPTH_DEF,
    parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [brb_pkg::CAP_W-1:0]        cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [brb_pkg::S_TDATA_W-1:0]    s_tdata,   // data[7:0], count[18:8], zero fill
    input  logic [brb_pkg::FUNC_W-1:0]       s_tuser,   // func[2:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0]    m_tdata,   // data_res[7:0], ok[8], used[19:9],
                                                         // free[30:20], zero fill
    output logic                             m_tuser,   // has_data
    output logic                             m_tlast
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW      = $clog2(MAX_RUN + 1);
    localparam int CAP_MAX = (DEPTH < 2047) ? DEPTH : 2047;

    localparam logic [brb_pkg::CAP_W-1:0] CAP_MAX_V = brb_pkg::CAP_W'(CAP_MAX);
    localparam logic [brb_pkg::CAP_W-1:0] CAP_RST_V =
        (brb_pkg::CAP_RESET > CAP_MAX) ? CAP_MAX_V : brb_pkg::CAP_W'(brb_pkg::CAP_RESET);

    brb_pkg::state_t state_reg, state_next;

    logic [brb_pkg::CAP_W-1:0]   cap_reg;
    logic [brb_pkg::CAP_W-1:0]   fill_reg, fill_next;
    logic [AW-1:0]               rd_reg, rd_next;
    logic [AW-1:0]               wr_reg, wr_next;
    logic [AW-1:0]               run_ptr_reg, run_ptr_next;
    logic [LW-1:0]               run_left_reg, run_left_next;

    logic                        m_valid_reg, m_valid_next;
    logic [brb_pkg::BYTE_W-1:0]  m_data_reg, m_data_next;
    logic                        m_has_reg, m_has_next;
    logic                        m_ok_reg, m_ok_next;
    logic                        m_last_reg, m_last_next;
    logic [brb_pkg::CAP_W-1:0]   m_used_reg, m_used_next;
    logic [brb_pkg::CAP_W-1:0]   m_free_reg, m_free_next;

    logic [brb_pkg::BYTE_W-1:0]  mem [DEPTH];
    logic [brb_pkg::BYTE_W-1:0]  mem_q;
    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_addr;

    logic [brb_pkg::FUNC_W-1:0]  in_func;
    logic [brb_pkg::BYTE_W-1:0]  in_data;
    logic [brb_pkg::COUNT_W-1:0] in_count;

    logic                        out_free;
    logic                        s_fire;
    logic [brb_pkg::CAP_W-1:0]   cap_eff;
    logic [brb_pkg::CAP_W-1:0]   room;
    logic [AW-1:0]               wrap_base;
    logic [brb_pkg::SUM_W-1:0]   wrap_sum;
    logic [AW-1:0]               wrap_res;
    logic [AW-1:0]               wr_inc;
    logic [AW-1:0]               run_ptr_inc;

    assign in_func  = s_tuser;
    assign in_data  = s_tdata[brb_pkg::BYTE_W-1:0];
    assign in_count = s_tdata[brb_pkg::BYTE_W +: brb_pkg::COUNT_W];

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == brb_pkg::ST_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_free_reg, m_used_reg, m_ok_reg, m_data_reg};

    assign room = cap_reg - fill_reg;

    always_comb begin
        if (cfg_data == '0) begin
            cap_eff = brb_pkg::CAP_W'(1);
        end else if (cfg_data > CAP_MAX_V) begin
            cap_eff = CAP_MAX_V;
        end else begin
            cap_eff = cfg_data;
        end
    end

    // shared wrap adder for pop, skip and advance
    always_comb begin
        wrap_base = (in_func == brb_pkg::FN_ADVANCE) ? wr_reg : rd_reg;
        wrap_sum  = brb_pkg::SUM_W'(wrap_base) + brb_pkg::SUM_W'(in_count);
        if (wrap_sum >= brb_pkg::SUM_W'(cap_reg)) begin
            wrap_sum = wrap_sum - brb_pkg::SUM_W'(cap_reg);
        end
        if (wrap_sum >= brb_pkg::SUM_W'(cap_reg)) begin
            wrap_sum = '0;
        end
        wrap_res = AW'(wrap_sum);
    end

    assign wr_inc = (brb_pkg::SUM_W'(wr_reg) + brb_pkg::SUM_W'(1) >= brb_pkg::SUM_W'(cap_reg))
                    ? '0 : AW'(wr_reg + 1'b1);
    assign run_ptr_inc =
        (brb_pkg::SUM_W'(run_ptr_reg) + brb_pkg::SUM_W'(1) >= brb_pkg::SUM_W'(cap_reg))
        ? '0 : AW'(run_ptr_reg + 1'b1);

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        run_ptr_next  = run_ptr_reg;
        run_left_next = run_left_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = wr_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_has_next   = m_has_reg;
        m_ok_next    = m_ok_reg;
        m_last_next  = m_last_reg;
        m_used_next  = m_used_reg;
        m_free_next  = m_free_reg;

        unique case (state_reg)
            brb_pkg::ST_IDLE: begin
                if (s_fire) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_has_next   = 1'b0;
                    m_ok_next    = 1'b0;
                    m_last_next  = 1'b1;
                    case (in_func) inside
                        brb_pkg::FN_PUSH: begin
                            if (fill_reg < cap_reg) begin
                                mem_we    = 1'b1;
                                wr_next   = wr_inc;
                                fill_next = fill_reg + 1'b1;
                                m_ok_next = 1'b1;
                            end
                        end
                        brb_pkg::FN_POP, brb_pkg::FN_PEEK: begin
                            if (in_count > brb_pkg::COUNT_W'(MAX_RUN) || in_count > fill_reg) begin
                                m_ok_next = 1'b0;
                            end else if (in_count == '0) begin
                                m_ok_next = 1'b1;
                            end else begin
                                // no immediate result; the run produces the words
                                m_valid_next  = m_valid_reg && !m_tready;
                                m_data_next   = m_data_reg;
                                m_has_next    = m_has_reg;
                                m_ok_next     = m_ok_reg;
                                m_last_next   = m_last_reg;
                                run_ptr_next  = rd_reg;
                                run_left_next = LW'(in_count);
                                state_next    = brb_pkg::ST_READ;
                                if (in_func == brb_pkg::FN_POP) begin
                                    rd_next   = wrap_res;
                                    fill_next = fill_reg - in_count;
                                end
                            end
                        end
                        brb_pkg::FN_CLEAR: begin
                            rd_next   = wr_reg;
                            fill_next = '0;
                            m_ok_next = 1'b1;
                        end
                        brb_pkg::FN_SKIP: begin
                            if (in_count <= fill_reg) begin
                                rd_next   = wrap_res;
                                fill_next = fill_reg - in_count;
                                m_ok_next = 1'b1;
                            end
                        end
                        brb_pkg::FN_ADVANCE: begin
                            if (in_count <= room) begin
                                wr_next   = wrap_res;
                                fill_next = fill_reg + in_count;
                                m_ok_next = 1'b1;
                            end
                        end
                        default: begin
                            m_ok_next = 1'b0;
                        end
                    endcase
                    if (state_next == brb_pkg::ST_IDLE) begin
                        m_used_next = fill_next;
                        m_free_next = cap_reg - fill_next;
                    end
                end
            end
            brb_pkg::ST_READ: begin
                mem_re       = 1'b1;
                mem_addr     = run_ptr_reg;
                run_ptr_next = run_ptr_inc;
                state_next   = brb_pkg::ST_DATA;
            end
            brb_pkg::ST_DATA: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = mem_q;
                    m_has_next    = 1'b1;
                    m_ok_next     = 1'b1;
                    m_last_next   = (run_left_reg == LW'(1));
                    m_used_next   = fill_reg;
                    m_free_next   = room;
                    run_left_next = run_left_reg - 1'b1;
                    if (run_left_reg == LW'(1)) begin
                        state_next = brb_pkg::ST_IDLE;
                    end else begin
                        mem_re       = 1'b1;
                        mem_addr     = run_ptr_reg;
                        run_ptr_next = run_ptr_inc;
                    end
                end
            end
            default: begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= in_data;
        end
        if (mem_re) begin
            mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= brb_pkg::ST_IDLE;
            cap_reg      <= CAP_RST_V;
            fill_reg     <= '0;
            rd_reg       <= '0;
            wr_reg       <= '0;
            run_ptr_reg  <= '0;
            run_left_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_ptr_reg  <= run_ptr_next;
            run_left_reg <= run_left_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg  <= cap_eff;
                fill_reg <= '0;
                rd_reg   <= '0;
                wr_reg   <= '0;
            end else begin
                fill_reg <= fill_next;
                rd_reg   <= rd_next;
                wr_reg   <= wr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_has_reg  <= m_has_next;
        m_ok_reg   <= m_ok_next;
        m_last_reg <= m_last_next;
        m_used_reg <= m_used_next;
        m_free_reg <= m_free_next;
    end

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap_reg)
        else $error("fill count exceeds capacity");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (brb_pkg::SUM_W'(rd_reg) < brb_pkg::SUM_W'(cap_reg)) &&
        (brb_pkg::SUM_W'(wr_reg) < brb_pkg::SUM_W'(cap_reg)))
        else $error("ring index beyond wrap point");

    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    a_run_word_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == brb_pkg::ST_DATA) && out_free |=> m_valid_reg && m_has_reg)
        else $error("run byte not presented");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == brb_pkg::ST_DATA) && out_free && (run_left_reg == LW'(1))
        |=> (state_reg == brb_pkg::ST_IDLE) && m_last_reg)
        else $error("run did not close with last word");

endmodule

// ----- tb/byte_ring_buffer_tb.sv -----
// Testbench for byte_ring_buffer: directed and random operation words checked against a ring model.
`timescale 1ns / 1ps

module byte_ring_buffer_tb;

    localparam int DEPTH        = brb_pkg::DEPTH_DEF;
    localparam int MAX_RUN      = brb_pkg::MAX_RUN_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 8;

    localparam logic [brb_pkg::FUNC_W-1:0] FN_RSVD_A = 3'd6;
    localparam logic [brb_pkg::FUNC_W-1:0] FN_RSVD_B = 3'd7;

    typedef struct packed {
        logic [brb_pkg::BYTE_W-1:0] dbyte;
        logic                       has_data;
        logic                       ok;
        logic                       last;
        logic [brb_pkg::CAP_W-1:0]  used;
        logic [brb_pkg::CAP_W-1:0]  room;
    } ring_result_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [brb_pkg::CAP_W-1:0]     cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [brb_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [brb_pkg::FUNC_W-1:0]    s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [brb_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    // ring model state
    logic [brb_pkg::BYTE_W-1:0] ring_mem [DEPTH];
    bit                         ring_written [DEPTH];
    int unsigned                rd_idx, wr_idx, fill, cap_eff;

    ring_result_t expected_results [$];
    ring_result_t got_res, want_res;

    int mismatches     = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    byte_ring_buffer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // data[7:0], count[18:8], zero fill
        .s_tuser   (s_tuser),   // func[2:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // data_res[7:0], ok[8], used[19:9], free[30:20], zero fill
        .m_tuser   (m_tuser),   // has_data
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned ring_wrap(input int unsigned idx, input int unsigned n);
        int unsigned s;
        s = idx + n;
        if (s >= cap_eff) s -= cap_eff;
        if (s >= cap_eff) s = 0;
        return s;
    endfunction

    function automatic void expect_word(input logic [brb_pkg::BYTE_W-1:0] dbyte,
                                        input logic has_data, input logic ok,
                                        input logic last);
        ring_result_t res;
        res.dbyte    = dbyte;
        res.has_data = has_data;
        res.ok       = ok;
        res.last     = last;
        res.used     = brb_pkg::CAP_W'(fill);
        res.room     = brb_pkg::CAP_W'(cap_eff - fill);
        expected_results.push_back(res);
    endfunction

    function automatic void ring_reset_model(input logic [brb_pkg::CAP_W-1:0] cap_val);
        cap_eff = cap_val;
        if (cap_eff == 0) cap_eff = 1;
        if (cap_eff > DEPTH) cap_eff = DEPTH;
        rd_idx = 0;
        wr_idx = 0;
        fill   = 0;
    endfunction

    function automatic void predict_word(input logic [brb_pkg::FUNC_W-1:0] fn,
                                         input logic [brb_pkg::BYTE_W-1:0] dat,
                                         input logic [brb_pkg::COUNT_W-1:0] cnt);
        logic                       done;
        int unsigned                idx;
        logic [brb_pkg::BYTE_W-1:0] run_bytes [$];
        done = 1'b0;
        case (fn)
            brb_pkg::FN_PUSH: begin
                if (fill < cap_eff) begin
                    ring_mem[wr_idx]     = dat;
                    ring_written[wr_idx] = 1'b1;
                    wr_idx = ring_wrap(wr_idx, 1);
                    fill++;
                    done = 1'b1;
                end
            end
            brb_pkg::FN_POP, brb_pkg::FN_PEEK: begin
                if (cnt > MAX_RUN || cnt > fill) begin
                    done = 1'b0;
                end else if (cnt == 0) begin
                    done = 1'b1;
                end else begin
                    idx = rd_idx;
                    repeat (cnt) begin
                        run_bytes.push_back(ring_mem[idx]);
                        idx = ring_wrap(idx, 1);
                    end
                    if (fn == brb_pkg::FN_POP) begin
                        rd_idx = idx;
                        fill  -= cnt;
                    end
                    foreach (run_bytes[i])
                        expect_word(run_bytes[i], 1'b1, 1'b1, i == run_bytes.size() - 1);
                    return;
                end
            end
            brb_pkg::FN_CLEAR: begin
                rd_idx = wr_idx;
                fill   = 0;
                done   = 1'b1;
            end
            brb_pkg::FN_SKIP: begin
                if (cnt <= fill) begin
                    rd_idx = ring_wrap(rd_idx, cnt);
                    fill  -= cnt;
                    done   = 1'b1;
                end
            end
            brb_pkg::FN_ADVANCE: begin
                if (cnt <= cap_eff - fill) begin
                    wr_idx = ring_wrap(wr_idx, cnt);
                    fill  += cnt;
                    done   = 1'b1;
                end
            end
            default: done = 1'b0;
        endcase
        expect_word('0, 1'b0, done, 1'b1);
    endfunction

    // bytes at the read side that were written since reset, up to one run
    function automatic int unsigned readable_run();
        int unsigned idx, n, lim;
        idx = rd_idx;
        n   = 0;
        lim = (fill < MAX_RUN) ? fill : MAX_RUN;
        while (n < lim && ring_written[idx]) begin
            n++;
            idx = ring_wrap(idx, 1);
        end
        return n;
    endfunction

    task automatic send_word(input logic [brb_pkg::FUNC_W-1:0] fn,
                             input logic [brb_pkg::BYTE_W-1:0] dat,
                             input logic [brb_pkg::COUNT_W-1:0] cnt);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {{(brb_pkg::S_TDATA_W - brb_pkg::COUNT_W - brb_pkg::BYTE_W){1'b0}},
                     cnt, dat};
        do @(posedge aclk); while (!s_tready);
        predict_word(fn, dat, cnt);
    endtask

    task automatic send_random_word();
        int unsigned                 pick, lim;
        logic [brb_pkg::FUNC_W-1:0]  fn;
        logic [brb_pkg::BYTE_W-1:0]  dat;
        logic [brb_pkg::COUNT_W-1:0] cnt;
        pick = $urandom_range(99);
        dat  = brb_pkg::BYTE_W'($urandom);
        cnt  = brb_pkg::COUNT_W'($urandom);
        if (pick < 42) begin
            fn = brb_pkg::FN_PUSH;
        end else if (pick < 72) begin
            fn  = (pick < 62) ? brb_pkg::FN_POP : brb_pkg::FN_PEEK;
            lim = readable_run();
            if (lim != 0 && $urandom_range(7) != 0)
                cnt = brb_pkg::COUNT_W'($urandom_range(lim, 1));
            else if ($urandom_range(1))
                cnt = brb_pkg::COUNT_W'($urandom_range(2047, MAX_RUN + 1));
            else if (fill < MAX_RUN)
                cnt = brb_pkg::COUNT_W'($urandom_range(MAX_RUN, fill + 1));
            else
                cnt = '0;
        end else if (pick < 81) begin
            fn = brb_pkg::FN_SKIP;
            if ($urandom_range(4) != 0) cnt = brb_pkg::COUNT_W'($urandom_range(fill, 0));
        end else if (pick < 90) begin
            fn  = brb_pkg::FN_ADVANCE;
            lim = cap_eff - fill;
            if (lim > 8) lim = 8;
            if ($urandom_range(4) != 0) cnt = brb_pkg::COUNT_W'($urandom_range(lim, 0));
        end else if (pick < 95) begin
            fn = brb_pkg::FN_CLEAR;
        end else begin
            fn = $urandom_range(1) ? FN_RSVD_A : FN_RSVD_B;
        end
        send_word(fn, dat, cnt);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [brb_pkg::CAP_W-1:0] cap_val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cap_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_reset_model(cap_val);
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(brb_pkg::FN_PEEK, 8'h00, 11'd0);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd1);
        send_word(brb_pkg::FN_SKIP, 8'h00, 11'd1);
        send_word(brb_pkg::FN_SKIP, 8'h00, 11'd0);
        send_word(brb_pkg::FN_PUSH, 8'h00, 11'd0);
        send_word(brb_pkg::FN_PUSH, 8'hFF, 11'h7FF);
        send_word(brb_pkg::FN_PUSH, 8'h5A, 11'd0);
        send_word(brb_pkg::FN_PEEK, 8'h00, 11'd3);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd2);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd65);
        send_word(brb_pkg::FN_PEEK, 8'h00, 11'd2);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd1);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd2047);
        send_word(brb_pkg::FN_ADVANCE, 8'h00, 11'd2047);
        send_word(brb_pkg::FN_ADVANCE, 8'h00, 11'd1024);
        send_word(brb_pkg::FN_PUSH, 8'h33, 11'd0);
        send_word(brb_pkg::FN_SKIP, 8'h00, 11'd1024);
        send_word(brb_pkg::FN_CLEAR, 8'hFF, 11'h7FF);
        send_word(FN_RSVD_A, 8'h00, 11'd0);
        send_word(FN_RSVD_B, 8'hFF, 11'h7FF);
    endtask

    task automatic test_capacity_limits();
        write_capacity(11'd0);
        send_word(brb_pkg::FN_PUSH, 8'hAA, 11'd0);
        send_word(brb_pkg::FN_PUSH, 8'h55, 11'd0);
        send_word(brb_pkg::FN_PEEK, 8'h00, 11'd1);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd1);
        send_word(brb_pkg::FN_ADVANCE, 8'h00, 11'd1);
        send_word(brb_pkg::FN_SKIP, 8'h00, 11'd1);
        send_word(brb_pkg::FN_ADVANCE, 8'h00, 11'd2);
        write_capacity(11'd1025);
        send_word(brb_pkg::FN_PUSH, 8'h81, 11'd0);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd1);
        write_capacity(11'd2);
        send_word(brb_pkg::FN_PUSH, 8'h11, 11'd0);
        send_word(brb_pkg::FN_PUSH, 8'h22, 11'd0);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd1);
        send_word(brb_pkg::FN_PUSH, 8'h33, 11'd0);
        send_word(brb_pkg::FN_POP, 8'h00, 11'd2);
    endtask

    task automatic test_random_phase(input logic [brb_pkg::CAP_W-1:0] cap_val,
                                     input int src_pct, input int snk_pct,
                                     input int n_words);
        write_capacity(cap_val);
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        repeat (n_words) send_random_word();
    endtask

    task automatic test_backpressure();
        write_capacity(11'd48);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_asked++;
        repeat (40) send_random_word();
        drain_results();
        repeat (20) send_random_word();
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_taken + 1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{m_tdata[7:0], m_tuser, m_tdata[8], m_tlast,
                        m_tdata[19:9], m_tdata[30:20]};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word: data %h has %b ok %b last %b used %0d free %0d",
                         $time, got_res.dbyte, got_res.has_data, got_res.ok, got_res.last,
                         got_res.used, got_res.room);
                mismatches++;
            end else begin
                want_res = expected_results.pop_front();
                if (got_res !== want_res) begin
                    $display("%0t: mismatch: expected data %h has %b ok %b last %b used %0d free %0d",
                             $time, want_res.dbyte, want_res.has_data, want_res.ok,
                             want_res.last, want_res.used, want_res.room);
                    $display("%0t:           actual data %h has %b ok %b last %b used %0d free %0d",
                             $time, got_res.dbyte, got_res.has_data, got_res.ok,
                             got_res.last, got_res.used, got_res.room);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        ring_reset_model(brb_pkg::CAP_W'(brb_pkg::CAP_RESET));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity_limits();
        test_random_phase(11'd24, 0, 0, 110);
        test_random_phase(11'd1, 75, 0, 110);
        test_random_phase(brb_pkg::CAP_W'($urandom_range(100, 2)), 0, 75, 110);
        test_random_phase(11'd2047, 25, 25, 110);
        test_backpressure();
        drain_results();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
